@@ rtl/iat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iat_pkg
// Shared types, codes and the keyword table of the indentation-aware
// tokenizer: token kinds, error codes, state codes and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iat_pkg;

	// default sizes
	localparam int MAX_TEXT_DEF     = 32;
	localparam int INDENT_DEPTH_DEF = 16;
	localparam int KW_LEN           = 6;

	localparam logic [30:0] FIRST_LINE_RESET = 31'd1;

	// token kinds
	localparam logic [5:0] K_IND    = 6'd0;
	localparam logic [5:0] K_DED    = 6'd1;
	localparam logic [5:0] K_NEWL   = 6'd2;
	localparam logic [5:0] K_INT    = 6'd3;
	localparam logic [5:0] K_VAR    = 6'd4;
	localparam logic [5:0] K_STRING = 6'd5;
	localparam logic [5:0] K_BOOL   = 6'd6;
	localparam logic [5:0] K_IF     = 6'd7;
	localparam logic [5:0] K_ELSE   = 6'd8;
	localparam logic [5:0] K_WHILE  = 6'd9;
	localparam logic [5:0] K_DEC    = 6'd10;
	localparam logic [5:0] K_FOR    = 6'd11;
	localparam logic [5:0] K_AND    = 6'd12;
	localparam logic [5:0] K_OR     = 6'd13;
	localparam logic [5:0] K_FUN    = 6'd14;
	localparam logic [5:0] K_RETURN = 6'd15;
	localparam logic [5:0] K_PLUS   = 6'd16;
	localparam logic [5:0] K_MINUS  = 6'd17;
	localparam logic [5:0] K_STAR   = 6'd18;
	localparam logic [5:0] K_SLASH  = 6'd19;
	localparam logic [5:0] K_LPAR   = 6'd20;
	localparam logic [5:0] K_RPAR   = 6'd21;
	localparam logic [5:0] K_ASSIGN = 6'd22;
	localparam logic [5:0] K_EQEQ   = 6'd23;
	localparam logic [5:0] K_NE     = 6'd24;
	localparam logic [5:0] K_GT     = 6'd25;
	localparam logic [5:0] K_GE     = 6'd26;
	localparam logic [5:0] K_LT     = 6'd27;
	localparam logic [5:0] K_LE     = 6'd28;
	localparam logic [5:0] K_SEMI   = 6'd29;
	localparam logic [5:0] K_COMMA  = 6'd30;
	localparam logic [5:0] K_TEXT   = 6'd31;
	localparam logic [5:0] K_ERROR  = 6'd32;

	// error codes
	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_INDENT   = 4'd1;
	localparam logic [3:0] ERR_UNCLOSED = 4'd2;
	localparam logic [3:0] ERR_BANG     = 4'd3;
	localparam logic [3:0] ERR_AMP      = 4'd4;
	localparam logic [3:0] ERR_PIPE     = 4'd5;
	localparam logic [3:0] ERR_SYMBOL   = 4'd6;
	localparam logic [3:0] ERR_DEEP     = 4'd7;
	localparam logic [3:0] ERR_OVERFLOW = 4'd8;
	localparam logic [3:0] ERR_TOO_LONG = 4'd9;

	typedef enum logic [3:0] {
		M_IDLE, M_NUM, M_IDENT, M_STR, M_EQ, M_BANG, M_GT, M_LT, M_AMP, M_PIPE
	} scan_mode_t;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_IDED, S_CHAR, S_FIN, S_TEXT, S_FRESH, S_NEWL, S_EDED, S_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		E_IND, E_DED, E_ERR_INDENT, E_ERR_DEEP, E_CHAR, E_HEAD, E_TEXT, E_FRESH, E_NEWL
	} emit_sel_t;

	typedef enum logic [1:0] {CA_ABSORB, CA_EMIT, CA_CLOSE, CA_BREAK} char_act_t;

	typedef enum logic [1:0] {A_NEWL, A_FRESH, A_DONE} after_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [30:0] num;
		logic [7:0]  tch;
		logic [30:0] line;
		logic [15:0] col;
		logic [3:0]  err;
	} res_t;

	typedef struct packed {
		logic       accept;
		logic       lead_space;
		logic       line_inc;
		logic       push;
		logic       clr_als;
		logic       pop;
		logic       char_step;
		logic       fin_step;
		logic       fresh_step;
		logic       new_line;
		logic       line_reset;
		logic       text_next;
		logic       emit;
		emit_sel_t  sel;
		logic       flush;
	} iat_cmd_t;

	typedef struct packed {
		logic      halted;
		logic      eoi;
		logic      is_lf;
		logic      is_space;
		logic      als;
		logic      ls_nonzero;
		logic      ls_gt_top;
		logic      ls_lt_top;
		logic      top_ne_ls;
		logic      depth_full;
		logic      ded_more;
		logic      depth_gt1;
		char_act_t char_act;
		logic      fin_emits;
		logic      fin_text;
		logic      text_last;
		logic      fresh_emits;
		logic      res_err;
		logic      hold_v;
		logic      hold_ok;
	} iat_stat_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] kind;
		logic       num;
	} kw_res_t;

	// keyword lookup, w holds the first six characters, first in the top byte
	function automatic kw_res_t kw_lookup(input logic [2:0] n, input logic [47:0] w);
		kw_res_t r;
		r = '0;
		if (n == 3'd2 && w[47:32] == "if") begin
			r = '{1'b1, K_IF, 1'b0};
		end else if (n == 3'd4 && w[47:16] == "else") begin
			r = '{1'b1, K_ELSE, 1'b0};
		end else if (n == 3'd5 && w[47:8] == "while") begin
			r = '{1'b1, K_WHILE, 1'b0};
		end else if (n == 3'd3 && w[47:24] == "dec") begin
			r = '{1'b1, K_DEC, 1'b0};
		end else if (n == 3'd3 && w[47:24] == "for") begin
			r = '{1'b1, K_FOR, 1'b0};
		end else if (n == 3'd3 && w[47:24] == "and") begin
			r = '{1'b1, K_AND, 1'b0};
		end else if (n == 3'd2 && w[47:32] == "or") begin
			r = '{1'b1, K_OR, 1'b0};
		end else if (n == 3'd4 && w[47:16] == "true") begin
			r = '{1'b1, K_BOOL, 1'b1};
		end else if (n == 3'd5 && w[47:8] == "false") begin
			r = '{1'b1, K_BOOL, 1'b0};
		end else if (n == 3'd3 && w[47:24] == "fun") begin
			r = '{1'b1, K_FUN, 1'b0};
		end else if (n == 3'd6 && w == "return") begin
			r = '{1'b1, K_RETURN, 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/indentation_aware_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indentation_aware_tokenizer
// Indentation-sensitive lexer: source bytes in, tokens out, with indent and
// dedent tokens from leading spaces and text characters after names and
// strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one item: a source byte in
//   char_code, or end_of_input to close the text. Output channel
//   (out_valid/out_stall) gives zero or more result items per input item;
//   last_of_run marks the final one of that input.
//   cfg_write loads first_line_number (cfg_data) into the line counter;
//   write it only while the block is idle.
//   One item at a time, in sequencer phases: start and done for a leading
//   space or a blank line end, plus a char phase for a character that extends
//   a token, close and newline for a line end, char, close and fresh when one
//   token closes and the next starts; each dedent and text character adds a step.
//   Each result waits in the hold stage until the next result comes or the
//   item finishes, so the last one of an item shows up when it finishes.
//   Reset clears the line state, indent stack and queue; the line counter
//   returns to 1. A stalled receiver freezes the sequencer once both the
//   output register and the hold stage are full; input is stalled while an
//   item is in work. After an error result the block takes items and drops
//   them until reset.
// ----------------------------------------------------------------------------
module indentation_aware_tokenizer import iat_pkg::*; #(
	parameter int MAX_TEXT     = MAX_TEXT_DEF,
	parameter int INDENT_DEPTH = INDENT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [30:0] number_value,
	output logic [7:0]  text_char,
	output logic [30:0] line_number,
	output logic [15:0] column,
	output logic [3:0]  error_code,
	output logic        last_of_run,
	input  logic        cfg_write,
	input  logic [30:0] cfg_data
);

	iat_cmd_t  cmd;
	iat_stat_t stat;
	res_t      out_res;

	// sequencer
	iat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	iat_dp #(
		.MAX_TEXT     (MAX_TEXT),
		.INDENT_DEPTH (INDENT_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_res      (out_res),
		.out_last     (last_of_run)
	);

	// result fields
	assign token_kind   = out_res.kind;
	assign number_value = out_res.num;
	assign text_char    = out_res.tch;
	assign line_number  = out_res.line;
	assign column       = out_res.col;
	assign error_code   = out_res.err;

endmodule

@@ rtl/iat_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iat_ctrl
// Sequencer of the tokenizer: walks one source item through indent, scan,
// token, text, newline and dedent phases, one result per step at most.
// ----------------------------------------------------------------------------
module iat_ctrl import iat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  iat_stat_t stat,
	output iat_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	after_t      after_q, after_d;
	logic        emit_req;
	emit_sel_t   sel;
	logic        go;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= A_DONE;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
		end
	end

	// result request of the current phase
	always_comb begin
		emit_req = 1'b0;
		sel      = E_IND;
		unique case (state_q)
			S_START: begin
				if (!stat.eoi && !stat.is_lf && stat.als && !stat.is_space &&
				    stat.ls_gt_top) begin
					emit_req = 1'b1;
					sel      = stat.depth_full ? E_ERR_DEEP : E_IND;
				end
			end
			S_IDED: begin
				if (stat.ded_more) begin
					emit_req = 1'b1;
					sel      = E_DED;
				end else if (stat.top_ne_ls) begin
					emit_req = 1'b1;
					sel      = E_ERR_INDENT;
				end
			end
			S_CHAR: begin
				emit_req = (stat.char_act == CA_EMIT);
				sel      = E_CHAR;
			end
			S_FIN: begin
				emit_req = stat.fin_emits;
				sel      = E_HEAD;
			end
			S_TEXT: begin
				emit_req = 1'b1;
				sel      = E_TEXT;
			end
			S_FRESH: begin
				emit_req = stat.fresh_emits;
				sel      = E_FRESH;
			end
			S_NEWL: begin
				emit_req = 1'b1;
				sel      = E_NEWL;
			end
			S_EDED: begin
				emit_req = stat.depth_gt1;
				sel      = E_DED;
			end
			default: ;
		endcase
	end

	assign go       = !emit_req || stat.hold_ok;
	assign in_stall = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		after_d = after_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !stat.halted) state_d = S_START;
			end
			S_START: begin
				if (go) begin
					if (stat.eoi) begin
						if (stat.als) begin
							state_d = S_EDED;
						end else begin
							state_d = S_FIN;
							after_d = A_NEWL;
						end
					end else if (stat.is_lf) begin
						if (stat.als) begin
							state_d = S_DONE;
						end else begin
							state_d = S_FIN;
							after_d = A_NEWL;
						end
					end else if (stat.als && stat.is_space) begin
						state_d = S_DONE;
					end else if (stat.als && stat.ls_gt_top) begin
						state_d = stat.depth_full ? S_DONE : S_CHAR;
					end else if (stat.als && stat.ls_lt_top) begin
						state_d = S_IDED;
					end else begin
						state_d = S_CHAR;
					end
				end
			end
			S_IDED: begin
				if (go && !stat.ded_more) state_d = stat.top_ne_ls ? S_DONE : S_CHAR;
			end
			S_CHAR: begin
				if (go) begin
					unique case (stat.char_act)
						CA_CLOSE: begin
							state_d = S_FIN;
							after_d = A_DONE;
						end
						CA_BREAK: begin
							state_d = S_FIN;
							after_d = A_FRESH;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_FIN: begin
				if (go) begin
					if (emit_req && stat.res_err) begin
						state_d = S_DONE;
					end else if (stat.fin_text) begin
						state_d = S_TEXT;
					end else begin
						unique case (after_q)
							A_NEWL:  state_d = S_NEWL;
							A_FRESH: state_d = S_FRESH;
							default: state_d = S_DONE;
						endcase
					end
				end
			end
			S_TEXT: begin
				if (go && stat.text_last) begin
					unique case (after_q)
						A_NEWL:  state_d = S_NEWL;
						A_FRESH: state_d = S_FRESH;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_FRESH: begin
				if (go) state_d = S_DONE;
			end
			S_NEWL: begin
				if (go) state_d = stat.eoi ? S_EDED : S_DONE;
			end
			S_EDED: begin
				if (go && !stat.depth_gt1) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.hold_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd      = '0;
		cmd.sel  = sel;
		cmd.emit = emit_req && stat.hold_ok;
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_START: begin
				if (go) begin
					if (stat.eoi) begin
						cmd.line_inc = stat.als && stat.ls_nonzero;
					end else if (stat.is_lf) begin
						cmd.new_line = stat.als;
					end else if (stat.als && stat.is_space) begin
						cmd.lead_space = 1'b1;
					end else if (stat.als) begin
						cmd.clr_als = 1'b1;
						cmd.push    = stat.ls_gt_top && !stat.depth_full;
					end
				end
			end
			S_IDED:  cmd.pop        = go && stat.ded_more;
			S_CHAR:  cmd.char_step  = go;
			S_FIN:   cmd.fin_step   = go;
			S_TEXT:  cmd.text_next  = go;
			S_FRESH: cmd.fresh_step = go;
			S_NEWL:  cmd.new_line   = go;
			S_EDED: begin
				cmd.pop        = go && stat.depth_gt1;
				cmd.line_reset = !stat.depth_gt1;
			end
			S_DONE:  cmd.flush      = stat.hold_ok;
			default: ;
		endcase
	end

endmodule

@@ rtl/iat_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iat_dp
// Tokenizer datapath: line and column counters, indent stack, scanner
// state, text buffer memory, result building and the two-stage result
// queue that marks the last result of each item.
// ----------------------------------------------------------------------------
module iat_dp import iat_pkg::*; #(
	parameter int MAX_TEXT     = MAX_TEXT_DEF,
	parameter int INDENT_DEPTH = INDENT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	input  logic        cfg_write,
	input  logic [30:0] cfg_data,
	input  iat_cmd_t    cmd,
	output iat_stat_t   stat,
	input  logic        out_stall,
	output logic        out_valid,
	output res_t        out_res,
	output logic        out_last
);

	localparam int TW = $clog2(MAX_TEXT);
	localparam int LW = $clog2(MAX_TEXT + 1);
	localparam int SW = $clog2(INDENT_DEPTH);
	localparam int DW = $clog2(INDENT_DEPTH + 1);

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// scanner and line state
	logic [7:0]    c_q;
	logic          eoi_q;
	logic [30:0]   line_q;
	logic [15:0]   ls_q;
	logic [15:0]   cc_q;
	logic          als_q;
	scan_mode_t    mode_q;
	logic [30:0]   acc_q;
	logic [LW-1:0] len_q;
	logic [15:0]   tsc_q;
	logic [15:0]   fin_col_q;
	logic          close_q;
	logic          halted_q;
	logic [DW-1:0] depth_q;
	logic [15:0]   stack_q [INDENT_DEPTH];
	logic [7:0]    kw_q [KW_LEN];
	logic [TW-1:0] idx_q;
	logic [7:0]    rd_q;
	logic [7:0]    text_mem [MAX_TEXT];

	// result queue
	res_t hold_q;
	logic hold_v_q;
	res_t out_q;
	logic out_v_q;
	logic out_last_q;

	// character classes
	logic is_digit, is_alpha, is_quote, is_space, is_lf;
	assign is_digit = (c_q >= "0") && (c_q <= "9");
	assign is_alpha = ((c_q >= "a") && (c_q <= "z")) || ((c_q >= "A") && (c_q <= "Z")) ||
	                  (c_q == "_");
	assign is_quote = (c_q == "\"");
	assign is_space = (c_q == " ");
	assign is_lf    = (c_q == 8'd10);

	// indent stack top
	logic [15:0] top;
	assign top = stack_q[SW'(depth_q - DW'(1))];

	// number accumulate
	logic [3:0]  digit;
	logic [34:0] acc_wide;
	logic        ovf;
	assign digit    = 4'(c_q - "0");
	assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 35'(digit);
	assign ovf      = |acc_wide[34:31];

	logic text_full;
	assign text_full = (len_q >= LW'(MAX_TEXT));

	// keyword match on the first characters
	logic [2:0]  kw_n;
	logic [47:0] kw_w;
	kw_res_t     kw;
	assign kw_n = (len_q <= LW'(KW_LEN)) ? len_q[2:0] : 3'd0;
	assign kw_w = {kw_q[0], kw_q[1], kw_q[2], kw_q[3], kw_q[4], kw_q[5]};
	assign kw   = kw_lookup(kw_n, kw_w);

	// continuing a token with the current character
	char_act_t  char_act;
	logic [5:0] ch_kind;
	logic [3:0] ch_err;
	logic       ch_pair;
	always_comb begin
		char_act = CA_BREAK;
		ch_kind  = K_ERROR;
		ch_err   = ERR_TOO_LONG;
		ch_pair  = 1'b0;
		case (mode_q)
			M_NUM: begin
				ch_err = ERR_OVERFLOW;
				if (is_digit) char_act = ovf ? CA_EMIT : CA_ABSORB;
			end
			M_IDENT: begin
				if (is_digit || is_alpha) char_act = text_full ? CA_EMIT : CA_ABSORB;
			end
			M_STR: begin
				if (is_quote) char_act = CA_CLOSE;
				else          char_act = text_full ? CA_EMIT : CA_ABSORB;
			end
			M_EQ:   ch_pair = (c_q == "=");
			M_BANG: ch_pair = (c_q == "=");
			M_GT:   ch_pair = (c_q == "=");
			M_LT:   ch_pair = (c_q == "=");
			M_AMP:  ch_pair = (c_q == "&");
			M_PIPE: ch_pair = (c_q == "|");
			default: ;
		endcase
		if (ch_pair) begin
			char_act = CA_EMIT;
			ch_err   = ERR_NONE;
			case (mode_q)
				M_EQ:    ch_kind = K_EQEQ;
				M_BANG:  ch_kind = K_NE;
				M_GT:    ch_kind = K_GE;
				M_LT:    ch_kind = K_LE;
				M_AMP:   ch_kind = K_AND;
				default: ch_kind = K_OR;
			endcase
		end
	end

	// closing the pending token
	logic [5:0]  head_kind;
	logic [30:0] head_num;
	logic [3:0]  head_err;
	logic [15:0] head_col;
	always_comb begin
		head_kind = K_ERROR;
		head_num  = '0;
		head_err  = ERR_NONE;
		head_col  = tsc_q;
		if (close_q) begin
			head_kind = K_STRING;
			head_col  = fin_col_q;
		end else begin
			case (mode_q)
				M_NUM: begin
					head_kind = K_INT;
					head_num  = acc_q;
					head_col  = fin_col_q;
				end
				M_IDENT: begin
					head_kind = kw.hit ? kw.kind : K_VAR;
					head_num  = {30'd0, kw.num};
				end
				M_STR:   head_err  = ERR_UNCLOSED;
				M_EQ:    head_kind = K_ASSIGN;
				M_GT:    head_kind = K_GT;
				M_LT:    head_kind = K_LT;
				M_BANG:  head_err  = ERR_BANG;
				M_AMP:   head_err  = ERR_AMP;
				M_PIPE:  head_err  = ERR_PIPE;
				default: ;
			endcase
		end
	end

	// starting a token
	logic [5:0] fr_kind;
	logic [3:0] fr_err;
	logic       fr_emit;
	scan_mode_t fr_mode;
	always_comb begin
		fr_kind = K_ERROR;
		fr_err  = ERR_NONE;
		fr_emit = 1'b0;
		fr_mode = M_IDLE;
		if (is_digit) begin
			fr_mode = M_NUM;
		end else if (is_alpha) begin
			fr_mode = M_IDENT;
		end else begin
			case (c_q)
				"\"": fr_mode = M_STR;
				" ":  ;
				"=":  fr_mode = M_EQ;
				"!":  fr_mode = M_BANG;
				">":  fr_mode = M_GT;
				"<":  fr_mode = M_LT;
				"&":  fr_mode = M_AMP;
				"|":  fr_mode = M_PIPE;
				"+": begin fr_emit = 1'b1; fr_kind = K_PLUS;  end
				"-": begin fr_emit = 1'b1; fr_kind = K_MINUS; end
				"*": begin fr_emit = 1'b1; fr_kind = K_STAR;  end
				"/": begin fr_emit = 1'b1; fr_kind = K_SLASH; end
				"(": begin fr_emit = 1'b1; fr_kind = K_LPAR;  end
				")": begin fr_emit = 1'b1; fr_kind = K_RPAR;  end
				";": begin fr_emit = 1'b1; fr_kind = K_SEMI;  end
				",": begin fr_emit = 1'b1; fr_kind = K_COMMA; end
				default: begin
					fr_emit = 1'b1;
					fr_err  = ERR_SYMBOL;
				end
			endcase
		end
	end

	logic [15:0] text_col;
	assign text_col = close_q ? fin_col_q : tsc_q;

	// result selection
	res_t res;
	always_comb begin
		res      = '0;
		res.line = line_q;
		res.kind = K_ERROR;
		unique case (cmd.sel)
			E_IND: begin
				res.kind = K_IND;
				res.col  = 16'd1;
			end
			E_DED: begin
				res.kind = K_DED;
				res.col  = 16'd1;
			end
			E_ERR_INDENT: begin
				res.err = ERR_INDENT;
				res.col = 16'd1;
			end
			E_ERR_DEEP: begin
				res.err = ERR_DEEP;
				res.col = 16'd1;
			end
			E_CHAR: begin
				res.kind = ch_kind;
				res.err  = ch_err;
				res.col  = tsc_q;
			end
			E_HEAD: begin
				res.kind = head_kind;
				res.num  = head_num;
				res.err  = head_err;
				res.col  = head_col;
			end
			E_TEXT: begin
				res.kind = K_TEXT;
				res.tch  = rd_q;
				res.col  = text_col;
			end
			E_FRESH: begin
				res.kind = fr_kind;
				res.err  = fr_err;
				res.col  = cc_q;
			end
			E_NEWL: begin
				res.kind = K_NEWL;
				res.col  = sat_inc(cc_q);
			end
			default: ;
		endcase
	end

	// result queue control
	logic out_free, hold_ok, move;
	assign out_free = !out_v_q || !out_stall;
	assign hold_ok  = !hold_v_q || out_free;
	assign move     = (cmd.emit || cmd.flush) && hold_v_q;

	// status to the controller
	always_comb begin
		stat             = '0;
		stat.halted      = halted_q;
		stat.eoi         = eoi_q;
		stat.is_lf       = is_lf;
		stat.is_space    = is_space;
		stat.als         = als_q;
		stat.ls_nonzero  = (ls_q != 16'd0);
		stat.ls_gt_top   = (ls_q > top);
		stat.ls_lt_top   = (ls_q < top);
		stat.top_ne_ls   = (ls_q != top);
		stat.depth_full  = (depth_q >= DW'(INDENT_DEPTH));
		stat.depth_gt1   = (depth_q > DW'(1));
		stat.ded_more    = (depth_q > DW'(1)) && (top > ls_q);
		stat.char_act    = char_act;
		stat.fin_emits   = close_q || (mode_q != M_IDLE);
		stat.fin_text    = (close_q || ((mode_q == M_IDENT) && !kw.hit)) &&
		                   (len_q != '0);
		stat.text_last   = (LW'(idx_q) + LW'(1)) == len_q;
		stat.fresh_emits = fr_emit;
		stat.res_err     = (res.kind == K_ERROR);
		stat.hold_v      = hold_v_q;
		stat.hold_ok     = hold_ok;
	end

	// text buffer write
	logic          mem_we;
	logic [TW-1:0] mem_wa;
	logic [TW-1:0] rd_addr;
	assign mem_we  = (cmd.char_step && (char_act == CA_ABSORB) &&
	                  ((mode_q == M_IDENT) || (mode_q == M_STR))) ||
	                 (cmd.fresh_step && is_alpha && !is_digit);
	assign mem_wa  = cmd.fresh_step ? '0 : len_q[TW-1:0];
	assign rd_addr = cmd.text_next ? idx_q + TW'(1) : idx_q;

	always_ff @(posedge clk) begin
		if (mem_we) text_mem[mem_wa] <= c_q;
		rd_q <= text_mem[rd_addr];
	end

	// keyword window and item latch
	always_ff @(posedge clk) begin
		if (mem_we && (cmd.fresh_step || (len_q < LW'(KW_LEN)))) begin
			kw_q[cmd.fresh_step ? 3'd0 : len_q[2:0]] <= c_q;
		end
		if (cmd.accept) begin
			c_q   <= char_code;
			eoi_q <= end_of_input;
		end
	end

	// indent stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INDENT_DEPTH; i++) stack_q[i] <= 16'd0;
			depth_q <= DW'(1);
		end else if (cmd.push) begin
			stack_q[SW'(depth_q)] <= ls_q;
			depth_q <= depth_q + DW'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_q - DW'(1);
		end
	end

	// line, column and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= FIRST_LINE_RESET;
			ls_q      <= 16'd0;
			cc_q      <= 16'd0;
			als_q     <= 1'b1;
			mode_q    <= M_IDLE;
			acc_q     <= '0;
			len_q     <= '0;
			tsc_q     <= 16'd0;
			fin_col_q <= 16'd0;
			close_q   <= 1'b0;
			halted_q  <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cfg_write) begin
				line_q <= cfg_data;
			end else if (cmd.new_line || cmd.line_inc) begin
				line_q <= line_q + 31'd1;
			end
			if (cmd.emit && stat.res_err) halted_q <= 1'b1;
			if (cmd.accept) begin
				close_q   <= 1'b0;
				idx_q     <= '0;
				fin_col_q <= cc_q;
			end
			if (cmd.text_next) idx_q <= idx_q + TW'(1);
			if (cmd.lead_space) begin
				ls_q <= sat_inc(ls_q);
				cc_q <= sat_inc(cc_q);
			end
			if (cmd.clr_als) als_q <= 1'b0;
			if (cmd.new_line || cmd.line_reset) begin
				ls_q   <= 16'd0;
				cc_q   <= 16'd0;
				als_q  <= 1'b1;
				mode_q <= M_IDLE;
			end
			if (cmd.char_step) begin
				cc_q      <= sat_inc(cc_q);
				fin_col_q <= cc_q;
				case (char_act)
					CA_ABSORB: begin
						if (mode_q == M_NUM) acc_q <= acc_wide[30:0];
						else                 len_q <= len_q + LW'(1);
					end
					CA_EMIT: begin
						if (ch_pair) mode_q <= M_IDLE;
					end
					CA_CLOSE: begin
						close_q <= 1'b1;
						mode_q  <= M_IDLE;
					end
					default: ;
				endcase
			end
			if (cmd.fin_step) mode_q <= M_IDLE;
			if (cmd.fresh_step) begin
				tsc_q  <= cc_q;
				mode_q <= fr_mode;
				if (is_digit) acc_q <= {27'd0, digit};
				if (is_alpha) len_q <= LW'(1);
				if (is_quote) len_q <= '0;
			end
		end
	end

	// result queue: hold stage then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit)       hold_v_q <= 1'b1;
			else if (cmd.flush) hold_v_q <= 1'b0;
			if (move)           out_v_q  <= 1'b1;
			else if (out_free)  out_v_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) hold_q <= res;
		if (move) begin
			out_q      <= hold_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

@@ sim/indentation_aware_tokenizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indentation_aware_tokenizer_test
// Self-checking bench for the tokenizer. It streams source bytes through the
// input channel and predicts every token in a local lexer model that keeps
// its own indent stack, scan state and line counter. Each result item is
// matched against the oldest predicted token. Directed lines cover every
// token kind and the value limits. Line numbering is reloaded at its limits,
// then random well-formed programs run. The run ends with one randomly
// chosen error, which must halt the block.
// ----------------------------------------------------------------------------
module indentation_aware_tokenizer_test;
	import iat_pkg::*;

	typedef struct packed {
		logic [5:0]  kind;
		logic [30:0] num;
		logic [7:0]  tch;
		logic [30:0] line;
		logic [15:0] col;
		logic [3:0]  err;
		logic        last;
	} token_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        end_of_input;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  token_kind;
	logic [30:0] number_value;
	logic [7:0]  text_char;
	logic [30:0] line_number;
	logic [15:0] column;
	logic [3:0]  error_code;
	logic        last_of_run;
	logic        cfg_write;
	logic [30:0] cfg_data;

	indentation_aware_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .number_value(number_value),
		.text_char(text_char), .line_number(line_number),
		.column(column), .error_code(error_code), .last_of_run(last_of_run),
		.cfg_write(cfg_write), .cfg_data(cfg_data)
	);

	// predicted tokens, oldest first
	token_t token_q[$];
	int     fail_count;
	int     items_sent;
	bit     idle_on;
	byte unsigned line_bytes[$];

	// lexer model state
	int unsigned     lvl_stack[INDENT_DEPTH_DEF];
	int              depth;
	int unsigned     lead;
	bit              at_start;
	scan_mode_t      mode;
	longint unsigned acc;
	byte unsigned    tbuf[MAX_TEXT_DEF];
	int              tlen;
	int unsigned     tstart;
	int unsigned     colc;
	logic [30:0]     line_cnt;
	bit              halted;

	string kw_words[11] = '{"if", "else", "while", "dec", "for", "and", "or",
		"true", "false", "fun", "return"};
	string op_words[17] = '{"+", "-", "*", "/", "(", ")", "=", "==", "!=", ">",
		">=", "<", "<=", ";", ",", "&&", "||"};
	string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	function automatic int unsigned sat16(int unsigned v);
		return (v >= 65535) ? 65535 : v + 1;
	endfunction

	function automatic bit is_digit(byte unsigned c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(byte unsigned c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic void emit(logic [5:0] kind, longint unsigned num, logic [7:0] ch,
			int unsigned col, logic [3:0] err);
		token_t t;
		t.kind = kind;
		t.num  = num[30:0];
		t.tch  = ch;
		t.line = line_cnt;
		t.col  = col[15:0];
		t.err  = err;
		t.last = 1'b0;
		token_q.insert(token_q.size(), t);
	endfunction

	function automatic void lex_fail(logic [3:0] code, int unsigned col);
		emit(K_ERROR, 0, 0, col, code);
		halted = 1;
	endfunction

	function automatic void emit_text(logic [5:0] kind, int unsigned col);
		emit(kind, 0, 0, col, ERR_NONE);
		for (int i = 0; i < tlen; i++) emit(K_TEXT, 0, tbuf[i], col, ERR_NONE);
	endfunction

	// keyword or identifier
	function automatic void emit_word();
		string w;
		w = "";
		for (int i = 0; i < tlen; i++) w = $sformatf("%s%c", w, tbuf[i]);
		case (w)
			"if":     emit(K_IF, 0, 0, tstart, ERR_NONE);
			"else":   emit(K_ELSE, 0, 0, tstart, ERR_NONE);
			"while":  emit(K_WHILE, 0, 0, tstart, ERR_NONE);
			"dec":    emit(K_DEC, 0, 0, tstart, ERR_NONE);
			"for":    emit(K_FOR, 0, 0, tstart, ERR_NONE);
			"and":    emit(K_AND, 0, 0, tstart, ERR_NONE);
			"or":     emit(K_OR, 0, 0, tstart, ERR_NONE);
			"true":   emit(K_BOOL, 1, 0, tstart, ERR_NONE);
			"false":  emit(K_BOOL, 0, 0, tstart, ERR_NONE);
			"fun":    emit(K_FUN, 0, 0, tstart, ERR_NONE);
			"return": emit(K_RETURN, 0, 0, tstart, ERR_NONE);
			default:  emit_text(K_VAR, tstart);
		endcase
	endfunction

	// close the pending token
	function automatic void close_token(int unsigned prevcol);
		case (mode)
			M_NUM:   emit(K_INT, acc, 0, prevcol, ERR_NONE);
			M_IDENT: emit_word();
			M_STR:   lex_fail(ERR_UNCLOSED, tstart);
			M_EQ:    emit(K_ASSIGN, 0, 0, tstart, ERR_NONE);
			M_GT:    emit(K_GT, 0, 0, tstart, ERR_NONE);
			M_LT:    emit(K_LT, 0, 0, tstart, ERR_NONE);
			M_BANG:  lex_fail(ERR_BANG, tstart);
			M_AMP:   lex_fail(ERR_AMP, tstart);
			M_PIPE:  lex_fail(ERR_PIPE, tstart);
			default: ;
		endcase
		mode = M_IDLE;
	endfunction

	// start a token on a character
	function automatic void open_token(byte unsigned c, int unsigned col);
		tstart = col;
		if (is_digit(c)) begin
			mode = M_NUM;
			acc = c - "0";
		end else if (is_alpha(c)) begin
			mode = M_IDENT;
			tbuf[0] = c;
			tlen = 1;
		end else begin
			case (c)
				"\"": begin
					mode = M_STR;
					tlen = 0;
				end
				" ": ;
				"+": emit(K_PLUS, 0, 0, col, ERR_NONE);
				"-": emit(K_MINUS, 0, 0, col, ERR_NONE);
				"*": emit(K_STAR, 0, 0, col, ERR_NONE);
				"/": emit(K_SLASH, 0, 0, col, ERR_NONE);
				"(": emit(K_LPAR, 0, 0, col, ERR_NONE);
				")": emit(K_RPAR, 0, 0, col, ERR_NONE);
				";": emit(K_SEMI, 0, 0, col, ERR_NONE);
				",": emit(K_COMMA, 0, 0, col, ERR_NONE);
				"=": mode = M_EQ;
				"!": mode = M_BANG;
				">": mode = M_GT;
				"<": mode = M_LT;
				"&": mode = M_AMP;
				"|": mode = M_PIPE;
				default: lex_fail(ERR_SYMBOL, col);
			endcase
		end
	endfunction

	function automatic bit second_char(byte unsigned c, byte unsigned want, logic [5:0] kind);
		if (c != want) return 0;
		emit(kind, 0, 0, tstart, ERR_NONE);
		mode = M_IDLE;
		return 1;
	endfunction

	function automatic void scan_char(byte unsigned c);
		int unsigned prevcol;
		int unsigned col;
		longint unsigned v;
		prevcol = colc;
		col = sat16(prevcol);
		colc = col;
		case (mode)
			M_NUM: if (is_digit(c)) begin
				v = acc * 10 + (c - "0");
				if (v > 64'h7FFF_FFFF) lex_fail(ERR_OVERFLOW, tstart);
				else acc = v;
				return;
			end
			M_IDENT: if (is_alpha(c) || is_digit(c)) begin
				if (tlen >= MAX_TEXT_DEF) lex_fail(ERR_TOO_LONG, tstart);
				else begin
					tbuf[tlen] = c;
					tlen++;
				end
				return;
			end
			M_STR: begin
				if (c == "\"") begin
					emit_text(K_STRING, prevcol);
					mode = M_IDLE;
					return;
				end
				if (tlen >= MAX_TEXT_DEF) lex_fail(ERR_TOO_LONG, tstart);
				else begin
					tbuf[tlen] = c;
					tlen++;
				end
				return;
			end
			M_EQ:   if (second_char(c, "=", K_EQEQ)) return;
			M_BANG: if (second_char(c, "=", K_NE)) return;
			M_GT:   if (second_char(c, "=", K_GE)) return;
			M_LT:   if (second_char(c, "=", K_LE)) return;
			M_AMP:  if (second_char(c, "&", K_AND)) return;
			M_PIPE: if (second_char(c, "|", K_OR)) return;
			default: ;
		endcase
		close_token(prevcol);
		if (!halted) open_token(c, col);
	endfunction

	// indent or dedent on the first non-space character
	function automatic void set_indent();
		int unsigned top;
		top = lvl_stack[(depth - 1) % INDENT_DEPTH_DEF];
		at_start = 0;
		if (lead > top) begin
			if (depth >= INDENT_DEPTH_DEF) begin
				lex_fail(ERR_DEEP, 1);
				return;
			end
			lvl_stack[depth] = lead;
			depth++;
			emit(K_IND, 0, 0, 1, ERR_NONE);
		end else if (lead < top) begin
			while (depth > 1 && lvl_stack[depth - 1] > lead) begin
				depth--;
				emit(K_DED, 0, 0, 1, ERR_NONE);
			end
			if (lvl_stack[depth - 1] != lead) lex_fail(ERR_INDENT, 1);
		end
	endfunction

	function automatic void next_line();
		line_cnt = line_cnt + 31'd1;
		lead = 0;
		colc = 0;
		at_start = 1;
		mode = M_IDLE;
	endfunction

	function automatic void close_line();
		if (at_start) begin
			next_line();
			return;
		end
		close_token(colc);
		if (halted) return;
		emit(K_NEWL, 0, 0, sat16(colc), ERR_NONE);
		next_line();
	endfunction

	function automatic void lexer_reset();
		foreach (lvl_stack[i]) lvl_stack[i] = 0;
		depth = 1;
		lead = 0;
		at_start = 1;
		mode = M_IDLE;
		acc = 0;
		tlen = 0;
		tstart = 0;
		colc = 0;
		line_cnt = FIRST_LINE_RESET;
		halted = 0;
	endfunction

	// predict the tokens of one accepted item
	function automatic void lex_item(byte unsigned c, bit eoi);
		int n0;
		n0 = token_q.size();
		if (halted) return;
		if (eoi) begin
			if (at_start) begin
				if (lead > 0) next_line();
			end else begin
				close_line();
			end
			while (!halted && depth > 1) begin
				depth--;
				emit(K_DED, 0, 0, 1, ERR_NONE);
			end
			if (!halted) begin
				lead = 0;
				colc = 0;
				at_start = 1;
				mode = M_IDLE;
			end
		end else if (c == 8'd10) begin
			close_line();
		end else if (at_start && c == " ") begin
			lead = sat16(lead);
			colc = sat16(colc);
		end else begin
			if (at_start) set_indent();
			if (!halted) scan_char(c);
		end
		if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_on) stall_left = 0;
			else if (stall_left > 0) stall_left--;
			else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
			out_stall <= (stall_left > 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{token_kind, number_value, text_char, line_number, column,
				error_code, last_of_run};
			if (token_q.size() == 0) begin
				fail_count++;
				$display("%0t unexpected item: kind %0d num %0d ch %0d line %0d col %0d err %0d last %0b",
					$time, got.kind, got.num, got.tch, got.line, got.col, got.err, got.last);
			end else begin
				want = token_q.pop_front();
				if (got != want) begin
					fail_count++;
					$display("%0t mismatch: expected kind %0d num %0d ch %0d line %0d col %0d err %0d last %0b",
						$time, want.kind, want.num, want.tch, want.line, want.col, want.err, want.last);
					$display("%0t            actual kind %0d num %0d ch %0d line %0d col %0d err %0d last %0b",
						$time, got.kind, got.num, got.tch, got.line, got.col, got.err, got.last);
				end
			end
		end
	end

	// one source item, with an optional idle burst ahead of it
	task automatic send_item(byte unsigned c, bit eoi);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		lex_item(c, eoi);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic send_eoi();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// stop sending and let every predicted token drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_first_line(logic [30:0] v);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		line_cnt = v;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) line_bytes.insert(line_bytes.size(), s[i]);
	endtask

	// append one random well-formed token
	task automatic add_token();
		int n;
		byte unsigned b;
		case ($urandom_range(0, 5))
			0: case ($urandom_range(0, 3))
				0: add_str("0");
				1: add_str("2147483647");
				default: add_str($sformatf("%0d", $urandom_range(0, 999999)));
			endcase
			1: begin
				n = ($urandom_range(0, 7) == 0) ? MAX_TEXT_DEF : $urandom_range(1, 8);
				line_bytes.insert(line_bytes.size(), alnum[$urandom_range(0, 52)]);
				repeat (n - 1) line_bytes.insert(line_bytes.size(), alnum[$urandom_range(0, 62)]);
			end
			2: add_str(kw_words[$urandom_range(0, 10)]);
			3: begin
				n = ($urandom_range(0, 7) == 0) ? MAX_TEXT_DEF : $urandom_range(0, 6);
				line_bytes.insert(line_bytes.size(), "\"");
				repeat (n) begin
					do b = 8'($urandom_range(0, 255)); while (b == 8'd10 || b == "\"");
					line_bytes.insert(line_bytes.size(), b);
				end
				line_bytes.insert(line_bytes.size(), "\"");
			end
			default: add_str(op_words[$urandom_range(0, 16)]);
		endcase
	endtask

	// one random line at a legal indent, blank now and then
	task automatic send_random_line();
		int unsigned spaces;
		int k;
		line_bytes.delete();
		case ($urandom_range(0, 3))
			0: spaces = lvl_stack[$urandom_range(0, depth - 1)];
			1: spaces = (depth < INDENT_DEPTH_DEF) ? lvl_stack[depth - 1] + $urandom_range(1, 3)
				: lvl_stack[depth - 1];
			default: spaces = lvl_stack[depth - 1];
		endcase
		repeat (spaces) line_bytes.insert(line_bytes.size(), " ");
		if ($urandom_range(0, 9) != 0) begin
			k = $urandom_range(1, 5);
			for (int i = 0; i < k; i++) begin
				if (i > 0) line_bytes.insert(line_bytes.size(), " ");
				add_token();
			end
		end
		foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0);
		if ($urandom_range(0, 7) == 0) send_eoi();
		else send_item(8'd10, 1'b0);
	endtask

	// every token kind, limits and nested levels
	task automatic test_token_kinds();
		send_text("a_Z9 = 2147483647\n");
		send_text("  x>=(3);y<=4,z!=0\n");
		send_text("    \"q\"==1&&b||c>d<e+f-g*h/7\n");
		send_text("   \n\n");
		send_eoi();
		send_text("if else while dec for and or true false fun return\n");
		send_text("abcdefghijklmnopqrstuvwxyzABCDEF \"\"\n");
		send_eoi();
	endtask

	// numbering reloads, including the wrap of the line counter
	task automatic test_line_numbering();
		write_first_line(31'd0);
		send_text("a\n");
		write_first_line(31'h7FFF_FFFF);
		send_text("b\nc\n");
		write_first_line(31'($urandom_range(2, 32'h7FFF_FFFE)));
		send_text("d\n");
	endtask

	// random programs, quiet in the last stretch
	task automatic test_random_programs();
		int goal;
		int lines;
		goal = items_sent + 240;
		lines = 0;
		while (items_sent < goal) begin
			if (items_sent > goal - 90) idle_on = 0;
			send_random_line();
			lines++;
			if (lines == 6) wait_idle();
		end
		send_eoi();
	endtask

	// one error, then the block must drop everything
	task automatic test_error_halt();
		case ($urandom_range(0, 8))
			0: send_text("    a\n  a\n");
			1: send_text("\"abc\n");
			2: send_text("! ");
			3: send_text("&x");
			4: send_text("|x");
			5: case ($urandom_range(0, 2))
				0: send_item(8'd9, 1'b0);
				1: send_item(8'd13, 1'b0);
				default: send_item(8'($urandom_range(128, 255)), 1'b0);
			endcase
			6: for (int i = 1; i <= INDENT_DEPTH_DEF; i++) begin
				repeat (i) send_item(" ", 1'b0);
				send_text("a\n");
			end
			7: send_text("2147483648 ");
			default: send_text("abcdefghijklmnopqrstuvwxyzABCDEFG ");
		endcase
		send_text("ok 1\n");
		send_eoi();
	endtask

	// main sequence
	initial begin
		fail_count = 0;
		items_sent = 0;
		idle_on = 1;
		lexer_reset();
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		char_code    <= 8'd0;
		end_of_input <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_data     <= 31'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_token_kinds();
		test_line_numbering();
		test_random_programs();
		test_error_halt();
		wait_idle();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("[indentation_aware_tokenizer] OK");
		end else begin
			$display("[indentation_aware_tokenizer] ERROR");
		end
		$finish;
	end

	// timeout
	initial begin
		#50_000_000;
		$display("[indentation_aware_tokenizer] ERROR");
		$finish;
	end

endmodule
